// ----- rtl/qarc_pkg.sv -----
// shared types, constants and step functions for the quaternion angular rate core
package qarc_pkg;

   localparam int FRAC_BITS     = 14;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_LEN      = 32;
   localparam int CORD_N        = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

   localparam int Q_W      = 16;                   // quaternion component
   localparam int DT_W     = 24;                   // interval
   localparam int R_W      = 32;                   // delta quaternion component
   localparam int SQ_W     = 62;                   // sum of squares
   localparam int NORM_W   = 31;                   // vector norm
   localparam int SREM_W   = 35;                   // square root remainder
   localparam int SQRT_N   = SQ_W / 2;             // one result bit per cell
   localparam int C_W      = 36;                   // cordic x and y
   localparam int Z_W      = 34;                   // cordic angle
   localparam int ANG_W    = Z_W + 1;
   localparam int D_W      = 32;                   // divider remainder and divisor
   localparam int RQ_W     = 37;                   // rate quotient
   localparam int AQ_W     = 16;                   // axis quotient
   localparam int AN_W     = NORM_W + FRAC_BITS;   // axis numerator
   localparam int RATE_NUM = 703125;
   localparam int RATE_SH  = 19;
   localparam int IN_W     = 8 * Q_W + DT_W;
   localparam int OUT_W    = 32 + 3 * Q_W;

   typedef struct packed {
      logic               v;
      logic [DT_W-1:0]    dt;
      logic signed [R_W-1:0] rw;
      logic signed [R_W-1:0] rx;
      logic signed [R_W-1:0] ry;
      logic signed [R_W-1:0] rz;
      logic [SQ_W-1:0]    n;
      logic [SREM_W-1:0]  rem;
      logic [NORM_W-1:0]  res;
   } sq_type;

   typedef struct packed {
      logic               v;
      logic [DT_W-1:0]    dt;
      logic signed [R_W-1:0] rx;
      logic signed [R_W-1:0] ry;
      logic signed [R_W-1:0] rz;
      logic [NORM_W-1:0]  norm;
      logic signed [C_W-1:0] cx;
      logic signed [C_W-1:0] cy;
      logic signed [Z_W-1:0] cz;
   } cd_type;

   typedef struct packed {
      logic                         v;
      logic [DT_W-1:0]              dt;
      logic                         nz;
      logic                         pos;
      logic [2:0]                   neg;
      logic [NORM_W-1:0]            norm;
      logic [RQ_W-1:0]              rq_num;
      logic [D_W-1:0]               rq_rem;
      logic [RQ_W-1:0]              rq_q;
      logic [2:0][AQ_W-1:0]         an_lo;
      logic [2:0][D_W-1:0]          an_rem;
      logic [2:0][AQ_W-1:0]         an_q;
   } dv_type;

   // atan(2^-i), full turn = 2^32
   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'd536870912;
         5'd1:  a = 32'd316933406;
         5'd2:  a = 32'd167458907;
         5'd3:  a = 32'd85004756;
         5'd4:  a = 32'd42667331;
         5'd5:  a = 32'd21354465;
         5'd6:  a = 32'd10679838;
         5'd7:  a = 32'd5340245;
         5'd8:  a = 32'd2670163;
         5'd9:  a = 32'd1335087;
         5'd10: a = 32'd667544;
         5'd11: a = 32'd333772;
         5'd12: a = 32'd166886;
         5'd13: a = 32'd83443;
         5'd14: a = 32'd41722;
         5'd15: a = 32'd20861;
         5'd16: a = 32'd10430;
         5'd17: a = 32'd5215;
         5'd18: a = 32'd2608;
         5'd19: a = 32'd1304;
         5'd20: a = 32'd652;
         5'd21: a = 32'd326;
         5'd22: a = 32'd163;
         5'd23: a = 32'd81;
         5'd24: a = 32'd41;
         5'd25: a = 32'd20;
         5'd26: a = 32'd10;
         5'd27: a = 32'd5;
         5'd28: a = 32'd3;
         5'd29: a = 32'd1;
         5'd30: a = 32'd1;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

   // one restoring division step: {new remainder, quotient bit}
   function automatic logic [D_W:0] div_step(input logic [D_W-1:0] rem, input logic b,
                                             input logic [D_W-1:0] d);
      logic [D_W:0] t;
      logic [D_W:0] dd;
      logic [D_W:0] diff;
      t    = {rem, b};
      dd   = {1'b0, d};
      diff = t - dd;
      if (t >= dd) begin
         return {diff[D_W-1:0], 1'b1};
      end
      return {t[D_W-1:0], 1'b0};
   endfunction

endpackage

// ----- rtl/qarc_front.sv -----
// delta quaternion products, truncation and sum of squares of the vector part
module qarc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_v,
   input  logic [qarc_pkg::IN_W-1:0]    in_data,
   output qarc_pkg::sq_type             sq_out
);

   logic signed [15:0] pw, px, py, pz, aw, ax, ay, az;
   logic signed [31:0] p_in [16];
   logic signed [31:0] p_ff [16];
   logic               v1_ff, v2_ff, v3_ff;
   logic [qarc_pkg::DT_W-1:0] dt1_ff, dt2_ff, dt3_ff;
   logic signed [33:0] s_w, s_x, s_y, s_z;
   logic signed [31:0] r_in [4];
   logic signed [31:0] r2_ff [4];
   logic signed [31:0] r3_ff [4];
   logic [60:0]        sqx_ff, sqy_ff, sqz_ff;
   logic signed [63:0] mx, my, mz;
   qarc_pkg::sq_type   sq_ff;

   assign pw = in_data[15:0];
   assign px = in_data[31:16];
   assign py = in_data[47:32];
   assign pz = in_data[63:48];
   assign aw = in_data[79:64];
   assign ax = in_data[95:80];
   assign ay = in_data[111:96];
   assign az = in_data[127:112];

   assign p_in[0]  = aw * pw;
   assign p_in[1]  = ax * px;
   assign p_in[2]  = ay * py;
   assign p_in[3]  = az * pz;
   assign p_in[4]  = aw * px;
   assign p_in[5]  = ax * pw;
   assign p_in[6]  = ay * pz;
   assign p_in[7]  = az * py;
   assign p_in[8]  = aw * py;
   assign p_in[9]  = ax * pz;
   assign p_in[10] = ay * pw;
   assign p_in[11] = az * px;
   assign p_in[12] = aw * pz;
   assign p_in[13] = ax * py;
   assign p_in[14] = ay * px;
   assign p_in[15] = az * pw;

   function automatic logic signed [31:0] cut2(input logic signed [33:0] s);
      logic [33:0] m;
      logic [33:0] m2;
      m  = s[33] ? 34'(-s) : 34'(s);
      m2 = m >> 2;
      return s[33] ? 32'(-$signed(m2)) : 32'(m2);
   endfunction

   always_comb begin
      s_w = 34'(p_ff[0]) + 34'(p_ff[1]) + 34'(p_ff[2]) + 34'(p_ff[3]);
      s_x = -34'(p_ff[4]) + 34'(p_ff[5]) - 34'(p_ff[6]) + 34'(p_ff[7]);
      s_y = -34'(p_ff[8]) + 34'(p_ff[9]) + 34'(p_ff[10]) - 34'(p_ff[11]);
      s_z = -34'(p_ff[12]) - 34'(p_ff[13]) + 34'(p_ff[14]) + 34'(p_ff[15]);
      r_in[0] = cut2(s_w);
      r_in[1] = cut2(s_x);
      r_in[2] = cut2(s_y);
      r_in[3] = cut2(s_z);
   end

   assign mx = r2_ff[1] * r2_ff[1];
   assign my = r2_ff[2] * r2_ff[2];
   assign mz = r2_ff[3] * r2_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         sq_ff <= '0;
      end else if (en) begin
         v1_ff <= in_v;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         sq_ff.v   <= v3_ff;
         sq_ff.dt  <= dt3_ff;
         sq_ff.rw  <= r3_ff[0];
         sq_ff.rx  <= r3_ff[1];
         sq_ff.ry  <= r3_ff[2];
         sq_ff.rz  <= r3_ff[3];
         sq_ff.n   <= 62'(sqx_ff) + 62'(sqy_ff) + 62'(sqz_ff);
         sq_ff.rem <= '0;
         sq_ff.res <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dt1_ff <= in_data[qarc_pkg::IN_W-1:8*qarc_pkg::Q_W];
         dt2_ff <= dt1_ff;
         dt3_ff <= dt2_ff;
         p_ff   <= p_in;
         r2_ff  <= r_in;
         r3_ff  <= r2_ff;
         sqx_ff <= mx[60:0];
         sqy_ff <= my[60:0];
         sqz_ff <= mz[60:0];
      end
   end

   assign sq_out = sq_ff;

endmodule

// ----- rtl/qarc_sqrt_cell.sv -----
// one result bit of the integer square root per cell
module qarc_sqrt_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  qarc_pkg::sq_type src,
   output qarc_pkg::sq_type dst
);

   qarc_pkg::sq_type dst_in, dst_ff;
   logic [qarc_pkg::SREM_W-1:0] rem2;
   logic [qarc_pkg::SREM_W-1:0] trial;

   always_comb begin
      dst_in = src;
      rem2   = {src.rem[qarc_pkg::SREM_W-3:0], src.n[qarc_pkg::SQ_W-1 -: 2]};
      trial  = {2'b00, src.res, 2'b01};
      dst_in.n = {src.n[qarc_pkg::SQ_W-3:0], 2'b00};
      if (rem2 >= trial) begin
         dst_in.rem = rem2 - trial;
         dst_in.res = {src.res[qarc_pkg::NORM_W-2:0], 1'b1};
      end else begin
         dst_in.rem = rem2;
         dst_in.res = {src.res[qarc_pkg::NORM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_ff <= '0;
      end else if (en) begin
         dst_ff <= dst_in;
      end
   end

   assign dst = dst_ff;

endmodule

// ----- rtl/qarc_cordic_cell.sv -----
// one vectoring micro-rotation of the angle cordic
module qarc_cordic_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [4:0]       shift,
   input  qarc_pkg::cd_type src,
   output qarc_pkg::cd_type dst
);

   qarc_pkg::cd_type dst_in, dst_ff;
   logic signed [qarc_pkg::C_W-1:0] xs, ys;
   logic signed [qarc_pkg::Z_W-1:0] at;

   always_comb begin
      dst_in = src;
      xs = src.cx >>> shift;
      ys = src.cy >>> shift;
      at = $signed({2'b00, qarc_pkg::atan_entry(shift)});
      if (src.cy > 0) begin
         dst_in.cx = src.cx + ys;
         dst_in.cy = src.cy - xs;
         dst_in.cz = src.cz + at;
      end else begin
         dst_in.cx = src.cx - ys;
         dst_in.cy = src.cy + xs;
         dst_in.cz = src.cz - at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_ff <= '0;
      end else if (en) begin
         dst_ff <= dst_in;
      end
   end

   assign dst = dst_ff;

endmodule

// ----- rtl/qarc_div_cell.sv -----
// one quotient bit of the rate division and, early in the row, of the three axis divisions
module qarc_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             axis_en,
   input  qarc_pkg::dv_type src,
   output qarc_pkg::dv_type dst
);

   qarc_pkg::dv_type dst_in, dst_ff;
   logic [qarc_pkg::D_W:0] rs;
   logic [qarc_pkg::D_W:0] as [3];

   always_comb begin
      dst_in = src;
      rs = qarc_pkg::div_step(src.rq_rem, src.rq_num[qarc_pkg::RQ_W-1],
                              qarc_pkg::D_W'(src.dt));
      dst_in.rq_rem = rs[qarc_pkg::D_W:1];
      dst_in.rq_num = {src.rq_num[qarc_pkg::RQ_W-2:0], 1'b0};
      dst_in.rq_q   = {src.rq_q[qarc_pkg::RQ_W-2:0], rs[0]};
      for (int j = 0; j < 3; j++) begin
         as[j] = qarc_pkg::div_step(src.an_rem[j], src.an_lo[j][qarc_pkg::AQ_W-1],
                                    qarc_pkg::D_W'(src.norm));
         if (axis_en) begin
            dst_in.an_rem[j] = as[j][qarc_pkg::D_W:1];
            dst_in.an_lo[j]  = {src.an_lo[j][qarc_pkg::AQ_W-2:0], 1'b0};
            dst_in.an_q[j]   = {src.an_q[j][qarc_pkg::AQ_W-2:0], as[j][0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_ff <= '0;
      end else if (en) begin
         dst_ff <= dst_in;
      end
   end

   assign dst = dst_ff;

endmodule

// ----- rtl/quaternion_angular_rate_core.sv -----
// Quaternion angular rate core: one item per clock, unless stalled, through a pipeline. The
// pipeline is made of rows of cells: 4 front stages (products, truncation, squares,
// sum), 31 square root cells, 16 cordic cells, 1 angle stage, 37 divider cells and the
// output register. A new item is taken every cycle the result register is free or being
// read; backpressure on the result side stalls the whole pipeline.
module quaternion_angular_rate_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // prev_w, prev_x, prev_y, prev_z, next_w, next_x, next_y, next_z, interval_us
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // rate_dps, axis_x, axis_y, axis_z
   output logic [79:0]  rsp_tdata,
   // rate_valid
   output logic [0:0]   rsp_tuser
);

   logic en;
   qarc_pkg::sq_type sq_chain [qarc_pkg::SQRT_N+1];
   qarc_pkg::cd_type cd_chain [qarc_pkg::CORD_N+1];
   qarc_pkg::dv_type dv_chain [qarc_pkg::RQ_W+1];
   qarc_pkg::cd_type cd_init;
   qarc_pkg::dv_type dv_in, dv_ff;
   qarc_pkg::sq_type sq_last;
   qarc_pkg::cd_type cd_last;
   qarc_pkg::dv_type dv_last;

   logic signed [qarc_pkg::ANG_W-1:0] ang;
   logic [qarc_pkg::ANG_W-1:0]        mag;
   logic [qarc_pkg::ANG_W+19:0]       prod;
   logic [qarc_pkg::ANG_W+20:0]       num;
   logic [qarc_pkg::R_W-1:0]          amag [3];
   logic [qarc_pkg::AN_W-1:0]         an [3];
   logic signed [qarc_pkg::R_W-1:0]   rc [3];

   logic [31:0]  rate;
   logic [15:0]  axis [3];
   logic [qarc_pkg::OUT_W-1:0] tdata_ff;
   logic         tuser_ff;
   logic         tvalid_ff;

   assign en         = !tvalid_ff || rsp_tready;
   assign req_tready = en;

   qarc_front u_front (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_v    (req_tvalid),
      .in_data (req_tdata),
      .sq_out  (sq_chain[0])
   );

   for (genvar k = 0; k < qarc_pkg::SQRT_N; k++) begin : g_sqrt
      qarc_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .src   (sq_chain[k]),
         .dst   (sq_chain[k+1])
      );
   end

   assign sq_last = sq_chain[qarc_pkg::SQRT_N];

   // start in the right half plane, pre-rotating by a quarter turn for a negative scalar
   always_comb begin
      cd_init.v    = sq_last.v;
      cd_init.dt   = sq_last.dt;
      cd_init.rx   = sq_last.rx;
      cd_init.ry   = sq_last.ry;
      cd_init.rz   = sq_last.rz;
      cd_init.norm = sq_last.res;
      if (sq_last.rw[qarc_pkg::R_W-1]) begin
         cd_init.cx = $signed(qarc_pkg::C_W'(sq_last.res));
         cd_init.cy = -qarc_pkg::C_W'(sq_last.rw);
         cd_init.cz = qarc_pkg::Z_W'(1) <<< 30;
      end else begin
         cd_init.cx = qarc_pkg::C_W'(sq_last.rw);
         cd_init.cy = $signed(qarc_pkg::C_W'(sq_last.res));
         cd_init.cz = '0;
      end
   end

   assign cd_chain[0] = cd_init;

   for (genvar k = 0; k < qarc_pkg::CORD_N; k++) begin : g_cordic
      qarc_cordic_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .shift (5'(k)),
         .src   (cd_chain[k]),
         .dst   (cd_chain[k+1])
      );
   end

   assign cd_last = cd_chain[qarc_pkg::CORD_N];

   // double the half angle, wrap, scale and set up the dividers
   always_comb begin
      ang = {cd_last.cz, 1'b0};
      if (ang > $signed(qarc_pkg::ANG_W'(64'h8000_0000))) begin
         ang = ang - $signed(qarc_pkg::ANG_W'(64'h1_0000_0000));
      end
      mag  = ang[qarc_pkg::ANG_W-1] ? qarc_pkg::ANG_W'(-ang) : qarc_pkg::ANG_W'(ang);
      prod = mag * 20'(qarc_pkg::RATE_NUM);
      num  = (qarc_pkg::ANG_W+21)'(prod) +
             ((qarc_pkg::ANG_W+21)'(cd_last.dt) << (qarc_pkg::RATE_SH - 1));
      rc[0] = cd_last.rx;
      rc[1] = cd_last.ry;
      rc[2] = cd_last.rz;
      dv_in.v      = cd_last.v;
      dv_in.dt     = cd_last.dt;
      dv_in.nz     = (cd_last.norm != '0);
      dv_in.pos    = !ang[qarc_pkg::ANG_W-1] && (ang != '0);
      dv_in.norm   = cd_last.norm;
      dv_in.rq_num = num[qarc_pkg::RATE_SH +: qarc_pkg::RQ_W];
      dv_in.rq_rem = '0;
      dv_in.rq_q   = '0;
      for (int j = 0; j < 3; j++) begin
         amag[j] = rc[j][qarc_pkg::R_W-1] ? qarc_pkg::R_W'(-rc[j]) : qarc_pkg::R_W'(rc[j]);
         an[j]   = ({amag[j][qarc_pkg::NORM_W-1:0], qarc_pkg::FRAC_BITS'(0)}) +
                   qarc_pkg::AN_W'(cd_last.norm >> 1);
         dv_in.neg[j]    = rc[j][qarc_pkg::R_W-1];
         dv_in.an_rem[j] = qarc_pkg::D_W'(an[j][qarc_pkg::AN_W-1:qarc_pkg::AQ_W]);
         dv_in.an_lo[j]  = an[j][qarc_pkg::AQ_W-1:0];
         dv_in.an_q[j]   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else if (en) begin
         dv_ff <= dv_in;
      end
   end

   assign dv_chain[0] = dv_ff;

   for (genvar k = 0; k < qarc_pkg::RQ_W; k++) begin : g_div
      qarc_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .axis_en ((k < qarc_pkg::AQ_W) ? 1'b1 : 1'b0),
         .src     (dv_chain[k]),
         .dst     (dv_chain[k+1])
      );
   end

   assign dv_last = dv_chain[qarc_pkg::RQ_W];

   // round is already folded into the numerators; saturate, apply signs and zero a zero interval or norm
   always_comb begin
      if (dv_last.pos) begin
         rate = (dv_last.rq_q > qarc_pkg::RQ_W'(64'h8000_0000)) ? 32'h8000_0000 :
                32'(-dv_last.rq_q);
      end else begin
         rate = (dv_last.rq_q > qarc_pkg::RQ_W'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF :
                dv_last.rq_q[31:0];
      end
      for (int j = 0; j < 3; j++) begin
         if (dv_last.neg[j]) begin
            axis[j] = (dv_last.an_q[j] > 16'd32768) ? 16'h8000 : 16'(-dv_last.an_q[j]);
         end else begin
            axis[j] = (dv_last.an_q[j] > 16'd32767) ? 16'h7FFF : dv_last.an_q[j];
         end
      end
      if ((dv_last.dt == '0) || !dv_last.nz) begin
         rate    = '0;
         axis[0] = '0;
         axis[1] = '0;
         axis[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tvalid_ff <= 1'b0;
      end else if (en) begin
         tvalid_ff <= dv_last.v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tdata_ff <= {axis[2], axis[1], axis[0], rate};
         tuser_ff <= (dv_last.dt != '0);
      end
   end

   assign rsp_tvalid   = tvalid_ff;
   assign rsp_tdata    = tdata_ff;
   assign rsp_tuser[0] = tuser_ff;

endmodule

// ----- rtl/qarc_checker.sv -----
// port-level checks for the quaternion angular rate core
module qarc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [79:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // held result keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // a stalled result register blocks the input side
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while output stalled");

   // zero interval gives an all-zero result
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("nonzero result for zero interval");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind quaternion_angular_rate_core qarc_checker u_qarc_checker (.*);
